@@ hdl/sli_pkg.sv @@
// Shared constants, codes and types for the sorted list insert/delete block.
`default_nettype none
package sli_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int VALUE_W  = 32;
  localparam int ACTION_W = 2;
  localparam int STATUS_W = 2;
  localparam int ECOUNT_W = 5;

  typedef logic [ACTION_W-1:0] action_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic signed [VALUE_W-1:0] value_t;

  localparam action_t ACT_INSERT = 2'd0;
  localparam action_t ACT_DELETE = 2'd1;
  localparam action_t ACT_POP_HEAD = 2'd2;
  localparam action_t ACT_POP_TAIL = 2'd3;

  localparam status_t STAT_OK       = 2'd0;
  localparam status_t STAT_FULL     = 2'd1;
  localparam status_t STAT_NOTFOUND = 2'd2;
  localparam status_t STAT_EMPTY    = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_PLACE,
    ST_DONE
  } sli_state_t;

  // Outcome of the shared comparator.
  typedef struct packed {
    logic lt;
    logic eq;
  } sli_cmp_t;

endpackage
`default_nettype wire

@@ hdl/sli_if.sv @@
// Valid/ready channel interfaces for request and result words.
`default_nettype none
interface sli_in_if;
  logic             valid;
  logic             ready;
  sli_pkg::action_t action;
  sli_pkg::value_t  value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

interface sli_out_if;
  logic                           valid;
  logic                           ready;
  sli_pkg::status_t               status;
  sli_pkg::value_t                result_value;
  logic [sli_pkg::ECOUNT_W-1:0]   entry_count;

  modport source (output valid, output status, output result_value, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input result_value, input entry_count,
                  output ready);
endinterface
`default_nettype wire

@@ hdl/sli_cmp.sv @@
// Shared signed comparator used by every scan step.
`default_nettype none
module sli_cmp (
  input  wire sli_pkg::value_t  a,
  input  wire sli_pkg::value_t  b,
  output sli_pkg::sli_cmp_t res
);
  import sli_pkg::*;

  assign res.lt = (a < b);
  assign res.eq = (a == b);

endmodule
`default_nettype wire

@@ hdl/sorted_list_insert_delete.sv @@
// Top level: sorted store acting as a double-ended priority queue.
// Usage:
//   in_chan  carries request words (action, value); out_chan returns one result word
//   (status, result_value, entry_count) per request, in request order.
//   Values are kept ascending in a single-port-write, single-port-read memory of
//   CAPACITY entries. One comparator is reused by a sequencer; each memory step is a
//   read issue (ST_READ), then a compare/write on the registered read data (ST_EVAL).
// Steps per request (p = insert position):
//   insert       : shifts entries >= value up from the top down, then writes the value
//                  at p (p = first entry >= value); slot 0 is written in ST_PLACE
//   delete/pop-hd: scans up to the match, then shifts the rest down
//   pop-tail     : reads the last entry;  full / empty / delete on empty: no memory step
// Throughput: one request at a time; in_chan.ready is high only while idle.
//   The memory read port and the comparator are shared by every step.
// Reset: synchronous, active low; clears the count, the sequencer state and the output
//   valid flag. Memory contents are not cleared, only entries below the count are read.
// Stall: a finished result waits in the output register; a following request may be
//   taken and worked on, and its result holds in the sequencer until the slot frees.
`default_nettype none
module sorted_list_insert_delete (
  input  wire logic  clk,
  input  wire logic  rst_n,
  sli_in_if.sink     in_chan,
  sli_out_if.source  out_chan
);
  import sli_pkg::*;

  // Entry memory
  value_t mem [CAPACITY];
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  value_t           wr_data;
  logic [IDX_W-1:0] rd_addr;
  value_t           rdata_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
  end

  // Sequencer state
  sli_state_t       state_r, state_nxt;
  action_t          op_r, op_nxt;
  value_t           val_r, val_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             found_r, found_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] pend_cnt_r, pend_cnt_nxt;
  status_t          res_stat_r, res_stat_nxt;
  value_t           res_val_r, res_val_nxt;

  // Output register
  logic             out_valid_r, out_valid_nxt;
  status_t          out_stat_r, out_stat_nxt;
  value_t           out_val_r, out_val_nxt;
  logic [CNT_W-1:0] out_cnt_r, out_cnt_nxt;

  sli_cmp_t         cmp;
  logic             last_pos;
  logic             slot_free;

  sli_cmp u_cmp (
    .a   (rdata_r),
    .b   (val_r),
    .res (cmp)
  );

  // Inserts read one below the target slot; scans read the slot itself.
  assign rd_addr   = (op_r == ACT_INSERT) ? (idx_r - IDX_W'(1)) : idx_r;
  assign last_pos  = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);
  assign slot_free = !out_valid_r || out_chan.ready;

  assign in_chan.ready         = (state_r == ST_IDLE);
  assign out_chan.valid        = out_valid_r;
  assign out_chan.status       = out_stat_r;
  assign out_chan.result_value = out_val_r;
  assign out_chan.entry_count  = ECOUNT_W'(out_cnt_r);

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    val_nxt       = val_r;
    idx_nxt       = idx_r;
    found_nxt     = found_r;
    count_nxt     = count_r;
    pend_cnt_nxt  = pend_cnt_r;
    res_stat_nxt  = res_stat_r;
    res_val_nxt   = res_val_r;
    out_valid_nxt = out_valid_r;
    out_stat_nxt  = out_stat_r;
    out_val_nxt   = out_val_r;
    out_cnt_nxt   = out_cnt_r;
    wr_en         = 1'b0;
    wr_addr       = idx_r;
    wr_data       = val_r;

    // Drop the result word once the receiver takes it.
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_chan.valid) begin
          op_nxt       = in_chan.action;
          val_nxt      = in_chan.value;
          found_nxt    = 1'b0;
          res_val_nxt  = '0;
          res_stat_nxt = STAT_OK;
          pend_cnt_nxt = count_r;
          idx_nxt      = '0;
          case (in_chan.action)
            ACT_INSERT: begin
              if (count_r == CNT_W'(CAPACITY)) begin
                res_stat_nxt = STAT_FULL;
                state_nxt    = ST_DONE;
              end else if (count_r == '0) begin
                state_nxt = ST_PLACE;
              end else begin
                idx_nxt   = IDX_W'(count_r);
                state_nxt = ST_READ;
              end
            end
            ACT_DELETE: begin
              if (count_r == '0) begin
                res_stat_nxt = STAT_NOTFOUND;
                state_nxt    = ST_DONE;
              end else begin
                state_nxt = ST_READ;
              end
            end
            ACT_POP_HEAD: begin
              if (count_r == '0) begin
                res_stat_nxt = STAT_EMPTY;
                state_nxt    = ST_DONE;
              end else begin
                state_nxt = ST_READ;
              end
            end
            default: begin
              if (count_r == '0) begin
                res_stat_nxt = STAT_EMPTY;
                state_nxt    = ST_DONE;
              end else begin
                idx_nxt   = IDX_W'(count_r - CNT_W'(1));
                state_nxt = ST_READ;
              end
            end
          endcase
        end
      end

      ST_READ: begin
        state_nxt = ST_EVAL;
      end

      ST_EVAL: begin
        case (op_r)
          ACT_INSERT: begin
            wr_en   = 1'b1;
            wr_addr = idx_r;
            if (!cmp.lt) begin
              // Shift the larger-or-equal entry up one slot.
              wr_data = rdata_r;
              idx_nxt = idx_r - IDX_W'(1);
              if (idx_r == IDX_W'(1)) begin
                state_nxt = ST_PLACE;
              end else begin
                state_nxt = ST_READ;
              end
            end else begin
              wr_data      = val_r;
              res_val_nxt  = val_r;
              pend_cnt_nxt = count_r + CNT_W'(1);
              state_nxt    = ST_DONE;
            end
          end
          ACT_POP_TAIL: begin
            res_val_nxt  = rdata_r;
            pend_cnt_nxt = count_r - CNT_W'(1);
            state_nxt    = ST_DONE;
          end
          default: begin
            if (found_r) begin
              // Close the gap left by the removed entry.
              wr_en   = 1'b1;
              wr_addr = idx_r - IDX_W'(1);
              wr_data = rdata_r;
            end else if (cmp.eq || (op_r == ACT_POP_HEAD)) begin
              found_nxt   = 1'b1;
              res_val_nxt = rdata_r;
            end
            if (last_pos) begin
              state_nxt = ST_DONE;
              if (found_r || cmp.eq || (op_r == ACT_POP_HEAD)) begin
                pend_cnt_nxt = count_r - CNT_W'(1);
              end else begin
                res_stat_nxt = STAT_NOTFOUND;
              end
            end else begin
              idx_nxt   = idx_r + IDX_W'(1);
              state_nxt = ST_READ;
            end
          end
        endcase
      end

      ST_PLACE: begin
        wr_en        = 1'b1;
        wr_addr      = idx_r;
        wr_data      = val_r;
        res_val_nxt  = val_r;
        pend_cnt_nxt = count_r + CNT_W'(1);
        state_nxt    = ST_DONE;
      end

      ST_DONE: begin
        // Hold until the output register can take the word.
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_stat_nxt  = res_stat_r;
          out_val_nxt   = res_val_r;
          out_cnt_nxt   = pend_cnt_r;
          count_nxt     = pend_cnt_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      found_r     <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    val_r      <= val_nxt;
    idx_r      <= idx_nxt;
    pend_cnt_r <= pend_cnt_nxt;
    res_stat_r <= res_stat_nxt;
    res_val_r  <= res_val_nxt;
    out_stat_r <= out_stat_nxt;
    out_val_r  <= out_val_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("stored count above capacity");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stat_r == STAT_FULL) |-> (out_cnt_r == CNT_W'(CAPACITY)))
    else $error("full status with store not full");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stat_r == STAT_EMPTY) |-> (out_cnt_r == '0))
    else $error("empty status with entries stored");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stat_r != STAT_OK) |-> (out_val_r == '0))
    else $error("error result carries a nonzero value");

  a_count_update: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(count_r) |-> ($past(state_r) == ST_DONE))
    else $error("count changed outside result hand-off");

endmodule
`default_nettype wire
